FILE: design/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared types and constants of the unsigned 32/64-bit divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udiv_pkg;

  localparam int unsigned WordWidth   = 64;
  localparam int unsigned NarrowWidth = 32;
  localparam int unsigned CntWidth    = 6;

  localparam logic [WordWidth-1:0] NarrowMask = 64'h0000_0000_ffff_ffff;

  // width command codes
  localparam logic CmdNarrow = 1'b0;
  localparam logic CmdWide   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } udiv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } udiv_status_t;

endpackage

`default_nettype wire

FILE: design/udiv_ctrl.sv
// ----------------------------------------------------------------------------
// udiv_ctrl
// Sequencer of the divider: load, one quotient bit per cycle, hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udiv_ctrl
  import udiv_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire udiv_status_t status_i,
  output udiv_cmd_t         cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/udiv_datapath.sv
// ----------------------------------------------------------------------------
// udiv_datapath
// Operand registers, shift-subtract step and bit counter of the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udiv_datapath
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire udiv_cmd_t            cmd_i,
  output udiv_status_t              status_o,
  input  wire logic                 command_i,
  input  wire logic [WordWidth-1:0] dividend_i,
  input  wire logic [WordWidth-1:0] divisor_i,
  output logic      [WordWidth-1:0] quotient_o,
  output logic      [WordWidth-1:0] remainder_o,
  output logic                      div_by_zero_o
);

  localparam logic [WordWidth-1:0] WideMask =
    {WordWidth{1'b1}} >> (WordWidth - DATA_WIDTH);
  localparam logic [CntWidth-1:0] WideLast   = CntWidth'(DATA_WIDTH - 1);
  localparam logic [CntWidth-1:0] NarrowLast = CntWidth'(NarrowWidth - 1);
  localparam int unsigned WideAlign   = WordWidth - DATA_WIDTH;
  localparam int unsigned NarrowAlign = WordWidth - NarrowWidth;

  logic [WordWidth-1:0] num_q, num_d;
  logic [WordWidth-1:0] den_q, den_d;
  logic [WordWidth-1:0] rem_q, rem_d;
  logic [WordWidth-1:0] quo_q, quo_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 wide_q, wide_d;
  logic                 dbz_q, dbz_d;

  logic [WordWidth-1:0] mask;
  logic [WordWidth-1:0] num_masked;
  logic [WordWidth-1:0] den_masked;
  logic [WordWidth:0]   rem_shift;
  logic [WordWidth:0]   diff;

  always_comb begin
    mask       = (command_i == CmdWide) ? WideMask : NarrowMask;
    num_masked = dividend_i & mask;
    den_masked = divisor_i & mask;
    // partial remainder grows one bit, borrow of the trial subtract decides
    rem_shift  = {rem_q, num_q[WordWidth-1]};
    diff       = rem_shift - {1'b0, den_q};

    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    wide_d = wide_q;
    dbz_d  = dbz_q;

    if (cmd_i.load) begin
      // dividend top bit of the selected width goes to bit 63
      num_d  = (command_i == CmdWide) ? (num_masked << WideAlign)
                                      : (num_masked << NarrowAlign);
      den_d  = den_masked;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = (command_i == CmdWide) ? WideLast : NarrowLast;
      wide_d = command_i;
      dbz_d  = (den_masked == '0);
    end else if (cmd_i.step) begin
      num_d = {num_q[WordWidth-2:0], 1'b0};
      cnt_d = cnt_q - CntWidth'(1);
      if (!diff[WordWidth]) begin
        rem_d = diff[WordWidth-1:0];
        quo_d = {quo_q[WordWidth-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[WordWidth-1:0];
        quo_d = {quo_q[WordWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    wide_q <= wide_d;
    dbz_q  <= dbz_d;
  end

  assign status_o.last = (cnt_q == '0);

  // a zero divisor forces an all-ones quotient of the width and a zero remainder
  assign quotient_o    = dbz_q ? (wide_q ? WideMask : NarrowMask) : quo_q;
  assign remainder_o   = dbz_q ? '0 : rem_q;
  assign div_by_zero_o = dbz_q;

endmodule

`default_nettype wire

FILE: design/unsigned_divider_32_64_core.sv
// ----------------------------------------------------------------------------
// unsigned_divider_32_64_core
// Unsigned 32-bit or DATA_WIDTH-bit divider with remainder and zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries command_i (0 = 32-bit, 1 = DATA_WIDTH-bit), dividend_i
//   and divisor_i on a valid/ready channel. Operand bits above the selected
//   width are ignored. The result (quotient_o, remainder_o, div_by_zero_o)
//   leaves on a second valid/ready channel; upper result bits are zero.
//   Dividing by zero gives an all-ones quotient of the selected width, a
//   zero remainder and div_by_zero_o set.
// Timing:
//   One request at a time. After acceptance the radix-2 restoring loop
//   produces one quotient bit per cycle, 32 bits for a 32-bit request or
//   DATA_WIDTH bits for a wide one; the single shift-subtract step sets
//   this rate. The result then waits for the receiver before the next
//   request is taken.
// Reset and stall:
//   Reset returns the sequencer to idle with in_ready_o high and clears the
//   bit counter; nothing else is reset. While the receiver holds out_ready_i
//   low the result stays on the outputs and no new request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unsigned_divider_32_64_core
  import udiv_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 command_i,
  input  wire logic [WordWidth-1:0] dividend_i,
  input  wire logic [WordWidth-1:0] divisor_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [WordWidth-1:0] quotient_o,
  output logic      [WordWidth-1:0] remainder_o,
  output logic                      div_by_zero_o
);

  udiv_cmd_t    cmd;
  udiv_status_t status;

  udiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  udiv_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .command_i     (command_i),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .quotient_o    (quotient_o),
    .remainder_o   (remainder_o),
    .div_by_zero_o (div_by_zero_o)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unsigned 32/64-bit divider. A short table of
// directed requests covers the operand extremes, both widths, divide by zero,
// equal operands, a divisor above the dividend and ignored upper operand bits.
// Random requests follow. Typed rows hold their results; the rest are held to a
// bit-level shift-subtract predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import udiv_pkg::*;

  localparam int unsigned DataWidth   = 64;
  localparam int unsigned RandomReqs  = 600;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned TailCycles  = 2 * (DataWidth + 2);
  localparam logic [WordWidth-1:0] WideMask = {WordWidth{1'b1}} >> (WordWidth - DataWidth);
  localparam logic [WordWidth-1:0] AllOnes  = {WordWidth{1'b1}};

  typedef struct packed {
    logic [WordWidth-1:0] quotient;
    logic [WordWidth-1:0] remainder;
    logic                 div_by_zero;
  } div_result_t;

  // typed = 1: the result columns hold the answer, else the predictor decides
  typedef struct packed {
    logic                 command;
    logic [WordWidth-1:0] dividend;
    logic [WordWidth-1:0] divisor;
    logic                 typed;
    logic [WordWidth-1:0] quotient;
    logic [WordWidth-1:0] remainder;
    logic                 div_by_zero;
  } div_row_t;

  localparam int unsigned NumRows = 18;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 command_i     = CmdNarrow;
  logic [WordWidth-1:0] dividend_i    = '0;
  logic [WordWidth-1:0] divisor_i     = '0;
  logic                 out_ready_i   = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [WordWidth-1:0] quotient_o;
  logic [WordWidth-1:0] remainder_o;
  logic                 div_by_zero_o;

  div_result_t quot_rem_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  div_row_t directed_rows [NumRows] = '{
    '{CmdNarrow, 64'h0, 64'h0, 1'b1, 64'hffff_ffff, 64'h0, 1'b1},
    '{CmdWide, 64'h0, 64'h0, 1'b1, AllOnes, 64'h0, 1'b1},
    // divisor nonzero only above the narrow width
    '{CmdNarrow, 64'd123, 64'hffff_ffff_0000_0000, 1'b1, 64'hffff_ffff, 64'h0, 1'b1},
    '{CmdWide, AllOnes, AllOnes, 1'b1, 64'h1, 64'h0, 1'b0},
    '{CmdNarrow, AllOnes, AllOnes, 1'b1, 64'h1, 64'h0, 1'b0},
    '{CmdNarrow, 64'hdead_beef_0000_0007, 64'h1234_5678_0000_0007, 1'b1,
      64'h1, 64'h0, 1'b0},
    '{CmdWide, AllOnes, 64'h1, 1'b1, AllOnes, 64'h0, 1'b0},
    '{CmdNarrow, AllOnes, 64'h1, 1'b1, 64'hffff_ffff, 64'h0, 1'b0},
    '{CmdWide, 64'd5, 64'd7, 1'b1, 64'h0, 64'd5, 1'b0},
    '{CmdWide, 64'h0, AllOnes, 1'b1, 64'h0, 64'h0, 1'b0},
    '{CmdNarrow, 64'd100, 64'd7, 1'b1, 64'd14, 64'd2, 1'b0},
    '{CmdWide, AllOnes, 64'd2, 1'b1, 64'h7fff_ffff_ffff_ffff, 64'h1, 1'b0},
    '{CmdNarrow, 64'hffff_ffff_0000_0003, 64'h5, 1'b1, 64'h0, 64'd3, 1'b0},
    '{CmdWide, 64'h1, 64'h1, 1'b1, 64'h1, 64'h0, 1'b0},
    '{CmdWide, 64'h8000_0000_0000_0000, 64'd3, 1'b0, 64'h0, 64'h0, 1'b0},
    // top remainder bit set during the loop
    '{CmdWide, AllOnes, 64'h8000_0000_0000_0001, 1'b0, 64'h0, 64'h0, 1'b0},
    '{CmdWide, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0,
      64'h0, 64'h0, 1'b0},
    '{CmdNarrow, 64'hffff_ffff_1234_5678, 64'h0000_0000_0000_1234, 1'b0,
      64'h0, 64'h0, 1'b0}
  };

  unsigned_divider_32_64_core #(
    .DATA_WIDTH(DataWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .dividend_i   (dividend_i),
    .divisor_i    (divisor_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quotient_o   (quotient_o),
    .remainder_o  (remainder_o),
    .div_by_zero_o(div_by_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic div_result_t compute_division(input logic cmd,
                                                   input logic [WordWidth-1:0] dvd,
                                                   input logic [WordWidth-1:0] dvs);
    logic [WordWidth-1:0] mask;
    logic [WordWidth-1:0] num;
    logic [WordWidth-1:0] den;
    logic [WordWidth-1:0] part;
    logic [WordWidth-1:0] quo;
    logic                 carry;
    int                   width;
    div_result_t          res;
    mask  = (cmd == CmdWide) ? WideMask : NarrowMask;
    width = (cmd == CmdWide) ? int'(DataWidth) : int'(NarrowWidth);
    num   = dvd & mask;
    den   = dvs & mask;
    res   = '0;
    if (den == '0) begin
      res.quotient    = mask;
      res.div_by_zero = 1'b1;
    end else if (den == num) begin
      res.quotient = 64'd1;
    end else if (den > num) begin
      res.remainder = num;
    end else begin
      part = '0;
      quo  = '0;
      for (int i = width - 1; i >= 0; i--) begin
        carry = part[WordWidth-1];
        part  = {part[WordWidth-2:0], num[i]};
        quo   = {quo[WordWidth-2:0], 1'b0};
        if (carry || part >= den) begin
          part   = part - den;
          quo[0] = 1'b1;
        end
      end
      res.quotient  = quo & mask;
      res.remainder = part & mask;
    end
    return res;
  endfunction

  function automatic logic [WordWidth-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string field, input int unsigned idx,
                                 input logic [WordWidth-1:0] got,
                                 input logic [WordWidth-1:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", idx, field, got, want);
    mismatch_count++;
  endtask

  // sender works in bursts; a gap can land on any cycle of a division
  task automatic offer_request(input logic cmd, input logic [WordWidth-1:0] dvd,
                               input logic [WordWidth-1:0] dvs, input div_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    dividend_i <= dvd;
    divisor_i  <= dvs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    quot_rem_queue.push_back(want);
  endtask

  initial begin : sender
    logic                 cmd;
    logic [WordWidth-1:0] dvd;
    logic [WordWidth-1:0] dvs;
    div_result_t          want;
    int unsigned          kind;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        want.quotient    = directed_rows[i].quotient;
        want.remainder   = directed_rows[i].remainder;
        want.div_by_zero = directed_rows[i].div_by_zero;
      end else begin
        want = compute_division(directed_rows[i].command, directed_rows[i].dividend,
                                directed_rows[i].divisor);
      end
      offer_request(directed_rows[i].command, directed_rows[i].dividend,
                    directed_rows[i].divisor, want);
    end

    for (int unsigned n = 0; n < RandomReqs; n++) begin
      // drain once mid-run
      if (n == RandomReqs / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (quot_rem_queue.size() != 0) @(posedge clk_i);
        burst_left = 0;
      end
      cmd  = ($urandom_range(0, 1) != 0) ? CmdWide : CmdNarrow;
      kind = $urandom_range(0, 9);
      dvd  = rand_word();
      dvs  = rand_word();
      case (kind)
        3, 4: dvs = dvs >> $urandom_range(8, 62);
        5: dvs = ($urandom_range(0, 1) != 0) ? '0 : {dvs[63:32], 32'h0};
        6: dvs = (cmd == CmdWide) ? dvd : {dvs[63:32], dvd[31:0]};
        7: begin
          dvd = {dvd[63:32] & {32{cmd == CmdNarrow}}, 32'($urandom_range(0, 1000))};
          dvs = {dvs[63:32] & {32{cmd == CmdNarrow}}, 32'($urandom_range(0, 50))};
        end
        8: begin
          dvs = dvs >> $urandom_range(33, 60);
          dvd = dvs * 64'($urandom_range(1, 5000)) + 64'($urandom_range(0, 3));
        end
        9: begin
          if ($urandom_range(0, 1) != 0) dvd = AllOnes;
          else dvs = AllOnes;
        end
        default: ;
      endcase
      offer_request(cmd, dvd, dvs, compute_division(cmd, dvd, dvs));
    end
    in_valid_i <= 1'b0;

    while (quot_rem_queue.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver stalls on a pattern of its own, with one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk_i);
        if (!held && results_seen >= 150) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (600) @(posedge clk_i);
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) != 0);
          2: out_ready_i <= ((cycle_count % 7) > 1);
          default: out_ready_i <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    div_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quot_rem_queue.size() == 0) begin
        report_mismatch("unexpected request result", results_seen, quotient_o, '0);
      end else begin
        want = quot_rem_queue.pop_front();
        if (quotient_o !== want.quotient)
          report_mismatch("quotient", results_seen, quotient_o, want.quotient);
        if (remainder_o !== want.remainder)
          report_mismatch("remainder", results_seen, remainder_o, want.remainder);
        if (div_by_zero_o !== want.div_by_zero)
          report_mismatch("div_by_zero", results_seen, 64'(div_by_zero_o),
                          64'(want.div_by_zero));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               quot_rem_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
